### hw/rtl/ddrpb_pkg.sv
package ddrpb_pkg;

   // Operand and result widths of the shared bit-serial multiply/divide unit.
   localparam int OPA_W    = 39;
   localparam int OPB_W    = 22;
   localparam int MUL_A_W  = 28;
   localparam int MUL_B_W  = 16;
   localparam int RES_W    = MUL_A_W + MUL_B_W;
   localparam int CNT_W    = 6;

   // Bridge pin codes.
   localparam logic [1:0] MODE_STOP = 2'd0;
   localparam logic [1:0] MODE_FWD  = 2'd1;
   localparam logic [1:0] MODE_BACK = 2'd2;

   // Saturated turn command.
   localparam logic [1:0] TURN_NONE  = 2'd0;
   localparam logic [1:0] TURN_RIGHT = 2'd1;
   localparam logic [1:0] TURN_LEFT  = 2'd2;

   // Register indexes.
   localparam logic [2:0] REG_MAX_PWM   = 3'd0;
   localparam logic [2:0] REG_RAMP_MS   = 3'd1;
   localparam logic [2:0] REG_PERIOD_MS = 3'd2;
   localparam logic [2:0] REG_GAIN_P    = 3'd3;
   localparam logic [2:0] REG_GAIN_I    = 3'd4;
   localparam logic [2:0] REG_GAIN_D    = 3'd5;
   localparam logic [2:0] REG_INT_LIMIT = 3'd6;

   // Quarter-sine polynomial, Q15.
   localparam logic [15:0] SIN_C0   = 16'd153;
   localparam logic [15:0] SIN_C1   = 16'd2611;
   localparam logic [15:0] SIN_C2   = 16'd21167;
   localparam logic [15:0] SIN_C3   = 16'd51472;
   localparam logic [15:0] RATIO_ONE = 16'd32768;

   localparam logic [OPB_W-1:0] TARGET_DIV = 22'd3276800;
   localparam logic [OPB_W-1:0] FIFTH_DIV  = 22'd5;
   localparam logic [OPB_W-1:0] MS_PER_S   = 22'd1000;
   localparam logic [6:0]       SPEED_MAX  = 7'd100;
   localparam logic [8:0]       TELE_FULL  = 9'd500;

   typedef enum logic [4:0] {
      ST_IDLE, ST_KDIV, ST_U, ST_T1, ST_T2, ST_T3, ST_R, ST_SM, ST_SMR,
      ST_TGT, ST_SLOW, ST_FAST, ST_TELE, ST_IMUL, ST_IDIV, ST_DMUL, ST_DDIV,
      ST_PMUL, ST_IGMUL, ST_DGMUL, ST_FIX, ST_OUT
   } seq_state_type;

   typedef struct packed {
      logic             start;
      logic             is_div;
      logic [OPA_W-1:0] a;
      logic [OPB_W-1:0] b;
   } mdu_cmd_type;

   typedef struct packed {
      logic             done;
      logic [RES_W-1:0] res;
   } mdu_rsp_type;

endpackage

### hw/rtl/diff_drive_ramp_pid_balancer.sv
// Each product and each quotient is formed bit by bit in the shared multiply/divide unit.
// One tick is in work at a time; the next one is accepted as soon as the previous result
// sits in the output register.
// Reset (synchronous, active high) loads the register defaults, clears the integral and
// the previous error, and empties the output register.
module diff_drive_ramp_pid_balancer #(
   parameter int SINE_TABLE_DEPTH = 256   // power of two, 16 to 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // direction, turn, speed command, elapsed_ms, left wheel speed, right wheel speed
   input  logic [71:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // left_duty, right_duty, bridge_mode, reported speed, zero fill
   output logic [47:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [22:0] csr_wdata
);

   localparam int DEPTH_LOG2 = $clog2(SINE_TABLE_DEPTH);
   localparam int XSH        = 15 - DEPTH_LOG2;
   localparam int AW         = ddrpb_pkg::OPA_W;
   localparam int BW         = ddrpb_pkg::OPB_W;

   ddrpb_pkg::seq_state_type state_ff, state_in;
   ddrpb_pkg::mdu_cmd_type   cmd;
   ddrpb_pkg::mdu_rsp_type   mrsp;

   logic        issued_ff, issued_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [42:0] rsp_data_ff, rsp_data_in;

   logic [15:0] max_pwm_ff, max_pwm_in;
   logic [15:0] ramp_ms_ff, ramp_ms_in;
   logic [9:0]  period_ms_ff, period_ms_in;
   logic [15:0] gain_p_ff, gain_p_in;
   logic [15:0] gain_i_ff, gain_i_in;
   logic [15:0] gain_d_ff, gain_d_in;
   logic [22:0] int_lim_ff, int_lim_in;
   logic signed [23:0] acc_ff, acc_in;
   logic signed [16:0] prev_ff, prev_in;

   logic [1:0]  mode_ff, mode_in;
   logic [1:0]  turn_ff, turn_in;
   logic [6:0]  spd_ff, spd_in;
   logic [15:0] elapsed_ff, elapsed_in;
   logic signed [15:0] lrpm_ff, lrpm_in;
   logic signed [15:0] rrpm_ff, rrpm_in;
   logic [14:0] x_ff, x_in;
   logic [14:0] u_ff, u_in;
   logic [15:0] t_ff, t_in;
   logic [15:0] r_ff, r_in;
   logic [22:0] sm_ff, sm_in;
   logic [38:0] prod_ff, prod_in;
   logic [15:0] target_ff, target_in;
   logic [15:0] slow_ff, slow_in;
   logic [16:0] fast_ff, fast_in;
   logic [8:0]  tele_ff, tele_in;
   logic signed [28:0] dterm_ff, dterm_in;
   logic [47:0] corr_ff, corr_in;
   logic [15:0] left_ff, left_in;
   logic [15:0] right_ff, right_in;

   logic signed [7:0]  dir_raw, turn_raw;
   logic [7:0]         spd_raw;
   logic [9:0]         per;
   logic signed [16:0] err;
   logic [16:0]        err_mag;
   logic signed [17:0] derr;
   logic [17:0]        derr_mag;
   logic [22:0]        acc_mag;
   logic [27:0]        dterm_mag;
   logic               pid_on;
   logic [16:0]        lb, rb;
   logic [15:0]        lclamp, rclamp;
   logic [16:0]        ratio;
   logic [24:0]        iq;
   logic [25:0]        inc;
   logic signed [25:0] isum, ilim;
   logic [27:0]        dq;
   logic [47:0]        pterm, iterm_s, iterm, dterm_t;
   logic signed [48:0] lsum, rsum, lsh, rsh;
   logic [15:0]        pid_l, pid_r;

   ddrpb_mdu u_mdu (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .rsp   (mrsp)
   );

   assign dir_raw  = req_tdata[7:0];
   assign turn_raw = req_tdata[15:8];
   assign spd_raw  = req_tdata[23:16];

   assign per       = (period_ms_ff == 10'd0) ? 10'd1 : period_ms_ff;
   assign err       = 17'(lrpm_ff) - 17'(rrpm_ff);
   assign err_mag   = err[16] ? 17'(-err) : 17'(err);
   assign derr      = 18'(err) - 18'(prev_ff);
   assign derr_mag  = derr[17] ? 18'(-derr) : 18'(derr);
   assign acc_mag   = acc_ff[23] ? 23'(-acc_ff) : 23'(acc_ff);
   assign dterm_mag = dterm_ff[28] ? 28'(-dterm_ff) : 28'(dterm_ff);
   assign pid_on    = (mode_ff != ddrpb_pkg::MODE_STOP) && (turn_ff == ddrpb_pkg::TURN_NONE)
                      && (target_ff != 16'd0);

   // Steering bias, then clamp to full scale.
   always_comb begin
      case (turn_ff)
         ddrpb_pkg::TURN_RIGHT: begin
            lb = 17'(slow_ff);
            rb = fast_ff;
         end
         ddrpb_pkg::TURN_LEFT: begin
            lb = fast_ff;
            rb = 17'(slow_ff);
         end
         default: begin
            lb = 17'(target_ff);
            rb = 17'(target_ff);
         end
      endcase
   end
   assign lclamp = (lb > 17'(max_pwm_ff)) ? max_pwm_ff : lb[15:0];
   assign rclamp = (rb > 17'(max_pwm_ff)) ? max_pwm_ff : rb[15:0];

   assign ratio   = mrsp.res[31:15];
   assign iq      = mrsp.res[24:0];
   assign inc     = err[16] ? 26'(-26'(iq)) : 26'(iq);
   assign isum    = 26'(acc_ff) + $signed(inc);
   assign ilim    = $signed({3'b000, int_lim_ff});
   assign dq      = mrsp.res[27:0];
   assign pterm   = err[16] ? 48'(-48'(mrsp.res[32:0])) : 48'(mrsp.res[32:0]);
   assign iterm_s = acc_ff[23] ? 48'(-48'(mrsp.res[38:0])) : 48'(mrsp.res[38:0]);
   assign iterm   = 48'($signed(iterm_s) >>> 8);
   assign dterm_t = dterm_ff[28] ? 48'(-48'(mrsp.res[43:0])) : 48'(mrsp.res[43:0]);

   // The correction, scaled down by 512, comes off the left wheel and goes onto the right one.
   assign lsum = $signed({24'd0, left_ff, 9'd0}) - 49'($signed(corr_ff));
   assign rsum = $signed({24'd0, right_ff, 9'd0}) + 49'($signed(corr_ff));
   assign lsh  = lsum >>> 9;
   assign rsh  = rsum >>> 9;
   assign pid_l = lsh[48] ? 16'd0
                : (lsh > $signed({33'd0, max_pwm_ff})) ? max_pwm_ff : lsh[15:0];
   assign pid_r = rsh[48] ? 16'd0
                : (rsh > $signed({33'd0, max_pwm_ff})) ? max_pwm_ff : rsh[15:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ddrpb_pkg::ST_IDLE;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         max_pwm_ff   <= 16'd255;
         ramp_ms_ff   <= 16'd500;
         period_ms_ff <= 10'd10;
         gain_p_ff    <= 16'd256;
         gain_i_ff    <= 16'd0;
         gain_d_ff    <= 16'd0;
         int_lim_ff   <= 23'd25600;
         acc_ff       <= '0;
         prev_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         rsp_valid_ff <= rsp_valid_in;
         max_pwm_ff   <= max_pwm_in;
         ramp_ms_ff   <= ramp_ms_in;
         period_ms_ff <= period_ms_in;
         gain_p_ff    <= gain_p_in;
         gain_i_ff    <= gain_i_in;
         gain_d_ff    <= gain_d_in;
         int_lim_ff   <= int_lim_in;
         acc_ff       <= acc_in;
         prev_ff      <= prev_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      mode_ff     <= mode_in;
      turn_ff     <= turn_in;
      spd_ff      <= spd_in;
      elapsed_ff  <= elapsed_in;
      lrpm_ff     <= lrpm_in;
      rrpm_ff     <= rrpm_in;
      x_ff        <= x_in;
      u_ff        <= u_in;
      t_ff        <= t_in;
      r_ff        <= r_in;
      sm_ff       <= sm_in;
      prod_ff     <= prod_in;
      target_ff   <= target_in;
      slow_ff     <= slow_in;
      fast_ff     <= fast_in;
      tele_ff     <= tele_in;
      dterm_ff    <= dterm_in;
      corr_ff     <= corr_in;
      left_ff     <= left_in;
      right_ff    <= right_in;
   end

   always_comb begin
      max_pwm_in   = max_pwm_ff;
      ramp_ms_in   = ramp_ms_ff;
      period_ms_in = period_ms_ff;
      gain_p_in    = gain_p_ff;
      gain_i_in    = gain_i_ff;
      gain_d_in    = gain_d_ff;
      int_lim_in   = int_lim_ff;
      if (csr_we) begin
         unique case (csr_index)
            ddrpb_pkg::REG_MAX_PWM:   max_pwm_in   = csr_wdata[15:0];
            ddrpb_pkg::REG_RAMP_MS:   ramp_ms_in   = csr_wdata[15:0];
            ddrpb_pkg::REG_PERIOD_MS: period_ms_in = csr_wdata[9:0];
            ddrpb_pkg::REG_GAIN_P:    gain_p_in    = csr_wdata[15:0];
            ddrpb_pkg::REG_GAIN_I:    gain_i_in    = csr_wdata[15:0];
            ddrpb_pkg::REG_GAIN_D:    gain_d_in    = csr_wdata[15:0];
            ddrpb_pkg::REG_INT_LIMIT: int_lim_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      acc_in       = acc_ff;
      prev_in      = prev_ff;
      mode_in      = mode_ff;
      turn_in      = turn_ff;
      spd_in       = spd_ff;
      elapsed_in   = elapsed_ff;
      lrpm_in      = lrpm_ff;
      rrpm_in      = rrpm_ff;
      x_in         = x_ff;
      u_in         = u_ff;
      t_in         = t_ff;
      r_in         = r_ff;
      sm_in        = sm_ff;
      prod_in      = prod_ff;
      target_in    = target_ff;
      slow_in      = slow_ff;
      fast_in      = fast_ff;
      tele_in      = tele_ff;
      dterm_in     = dterm_ff;
      corr_in      = corr_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      req_tready   = 1'b0;
      cmd.start    = 1'b0;
      cmd.is_div   = 1'b0;
      cmd.a        = '0;
      cmd.b        = '0;

      unique case (state_ff)
         ddrpb_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               mode_in = (dir_raw > 8'sd0) ? ddrpb_pkg::MODE_FWD
                       : (dir_raw < 8'sd0) ? ddrpb_pkg::MODE_BACK : ddrpb_pkg::MODE_STOP;
               turn_in = (turn_raw > 8'sd0) ? ddrpb_pkg::TURN_RIGHT
                       : (turn_raw < 8'sd0) ? ddrpb_pkg::TURN_LEFT : ddrpb_pkg::TURN_NONE;
               spd_in  = (spd_raw > 8'(ddrpb_pkg::SPEED_MAX)) ? ddrpb_pkg::SPEED_MAX
                                                             : spd_raw[6:0];
               elapsed_in = req_tdata[39:24];
               lrpm_in    = req_tdata[55:40];
               rrpm_in    = req_tdata[71:56];
               state_in   = ddrpb_pkg::ST_KDIV;
            end
         end
         ddrpb_pkg::ST_KDIV: begin
            if (mode_ff == ddrpb_pkg::MODE_STOP) begin
               target_in = '0;
               slow_in   = '0;
               fast_in   = '0;
               state_in  = ddrpb_pkg::ST_TELE;
            end else if (elapsed_ff >= ramp_ms_ff) begin
               r_in     = ddrpb_pkg::RATIO_ONE;
               state_in = ddrpb_pkg::ST_SM;
            end else begin
               cmd.start  = ~issued_ff;
               cmd.is_div = 1'b1;
               cmd.a      = AW'(elapsed_ff) << DEPTH_LOG2;
               cmd.b      = BW'(ramp_ms_ff);
               if (mrsp.done) begin
                  x_in     = 15'(mrsp.res[DEPTH_LOG2-1:0]) << XSH;
                  state_in = ddrpb_pkg::ST_U;
               end
            end
         end
         ddrpb_pkg::ST_U: begin
            cmd.start = ~issued_ff;
            cmd.a     = AW'(x_ff);
            cmd.b     = BW'(x_ff);
            if (mrsp.done) begin
               u_in     = mrsp.res[29:15];
               state_in = ddrpb_pkg::ST_T1;
            end
         end
         ddrpb_pkg::ST_T1: begin
            cmd.start = ~issued_ff;
            cmd.a     = AW'(u_ff);
            cmd.b     = BW'(ddrpb_pkg::SIN_C0);
            if (mrsp.done) begin
               t_in     = ddrpb_pkg::SIN_C1 - mrsp.res[30:15];
               state_in = ddrpb_pkg::ST_T2;
            end
         end
         ddrpb_pkg::ST_T2: begin
            cmd.start = ~issued_ff;
            cmd.a     = AW'(t_ff);
            cmd.b     = BW'(u_ff);
            if (mrsp.done) begin
               t_in     = ddrpb_pkg::SIN_C2 - mrsp.res[30:15];
               state_in = ddrpb_pkg::ST_T3;
            end
         end
         ddrpb_pkg::ST_T3: begin
            cmd.start = ~issued_ff;
            cmd.a     = AW'(t_ff);
            cmd.b     = BW'(u_ff);
            if (mrsp.done) begin
               t_in     = ddrpb_pkg::SIN_C3 - mrsp.res[30:15];
               state_in = ddrpb_pkg::ST_R;
            end
         end
         ddrpb_pkg::ST_R: begin
            cmd.start = ~issued_ff;
            cmd.a     = AW'(t_ff);
            cmd.b     = BW'(x_ff);
            if (mrsp.done) begin
               r_in     = (ratio > 17'(ddrpb_pkg::RATIO_ONE)) ? ddrpb_pkg::RATIO_ONE
                                                              : ratio[15:0];
               state_in = ddrpb_pkg::ST_SM;
            end
         end
         ddrpb_pkg::ST_SM: begin
            cmd.start = ~issued_ff;
            cmd.a     = AW'(max_pwm_ff);
            cmd.b     = BW'(spd_ff);
            if (mrsp.done) begin
               sm_in    = mrsp.res[22:0];
               state_in = ddrpb_pkg::ST_SMR;
            end
         end
         ddrpb_pkg::ST_SMR: begin
            cmd.start = ~issued_ff;
            cmd.a     = AW'(sm_ff);
            cmd.b     = BW'(r_ff);
            if (mrsp.done) begin
               prod_in  = mrsp.res[38:0];
               state_in = ddrpb_pkg::ST_TGT;
            end
         end
         ddrpb_pkg::ST_TGT: begin
            cmd.start  = ~issued_ff;
            cmd.is_div = 1'b1;
            cmd.a      = prod_ff;
            cmd.b      = ddrpb_pkg::TARGET_DIV;
            if (mrsp.done) begin
               target_in = mrsp.res[15:0];
               state_in  = ddrpb_pkg::ST_SLOW;
            end
         end
         ddrpb_pkg::ST_SLOW: begin
            cmd.start  = ~issued_ff;
            cmd.is_div = 1'b1;
            cmd.a      = AW'({target_ff, 2'b00});
            cmd.b      = ddrpb_pkg::FIFTH_DIV;
            if (mrsp.done) begin
               slow_in  = mrsp.res[15:0];
               state_in = ddrpb_pkg::ST_FAST;
            end
         end
         ddrpb_pkg::ST_FAST: begin
            cmd.start  = ~issued_ff;
            cmd.is_div = 1'b1;
            cmd.a      = AW'(19'({target_ff, 2'b00}) + 19'({target_ff, 1'b0}));
            cmd.b      = ddrpb_pkg::FIFTH_DIV;
            if (mrsp.done) begin
               fast_in  = mrsp.res[16:0];
               state_in = ddrpb_pkg::ST_TELE;
            end
         end
         ddrpb_pkg::ST_TELE: begin
            if (max_pwm_ff == 16'd0 || mrsp.done) begin
               tele_in  = (max_pwm_ff == 16'd0) ? 9'd0 : mrsp.res[8:0];
               left_in  = lclamp;
               right_in = rclamp;
               if (pid_on) begin
                  state_in = ddrpb_pkg::ST_IMUL;
               end else begin
                  acc_in   = '0;
                  state_in = ddrpb_pkg::ST_OUT;
               end
            end else begin
               cmd.start  = ~issued_ff;
               cmd.is_div = 1'b1;
               cmd.a      = AW'(25'(target_ff) * 25'(ddrpb_pkg::TELE_FULL));
               cmd.b      = BW'(max_pwm_ff);
            end
         end
         ddrpb_pkg::ST_IMUL: begin
            cmd.start = ~issued_ff;
            cmd.a     = AW'(err_mag);
            cmd.b     = BW'(per);
            if (mrsp.done) begin
               prod_in  = mrsp.res[38:0];
               state_in = ddrpb_pkg::ST_IDIV;
            end
         end
         ddrpb_pkg::ST_IDIV: begin
            cmd.start  = ~issued_ff;
            cmd.is_div = 1'b1;
            cmd.a      = AW'({prod_ff[26:0], 8'd0});
            cmd.b      = ddrpb_pkg::MS_PER_S;
            if (mrsp.done) begin
               if (isum > ilim) begin
                  acc_in = 24'(ilim);
               end else if (isum < -ilim) begin
                  acc_in = 24'(-ilim);
               end else begin
                  acc_in = 24'(isum);
               end
               state_in = ddrpb_pkg::ST_DMUL;
            end
         end
         ddrpb_pkg::ST_DMUL: begin
            cmd.start = ~issued_ff;
            cmd.a     = AW'(derr_mag);
            cmd.b     = ddrpb_pkg::MS_PER_S;
            if (mrsp.done) begin
               prod_in  = mrsp.res[38:0];
               state_in = ddrpb_pkg::ST_DDIV;
            end
         end
         ddrpb_pkg::ST_DDIV: begin
            cmd.start  = ~issued_ff;
            cmd.is_div = 1'b1;
            cmd.a      = prod_ff;
            cmd.b      = BW'(per);
            if (mrsp.done) begin
               dterm_in = derr[17] ? 29'(-29'(dq)) : 29'(dq);
               state_in = ddrpb_pkg::ST_PMUL;
            end
         end
         ddrpb_pkg::ST_PMUL: begin
            cmd.start = ~issued_ff;
            cmd.a     = AW'(err_mag);
            cmd.b     = BW'(gain_p_ff);
            if (mrsp.done) begin
               corr_in  = pterm;
               state_in = ddrpb_pkg::ST_IGMUL;
            end
         end
         ddrpb_pkg::ST_IGMUL: begin
            cmd.start = ~issued_ff;
            cmd.a     = AW'(acc_mag);
            cmd.b     = BW'(gain_i_ff);
            if (mrsp.done) begin
               corr_in  = corr_ff + iterm;
               state_in = ddrpb_pkg::ST_DGMUL;
            end
         end
         ddrpb_pkg::ST_DGMUL: begin
            cmd.start = ~issued_ff;
            cmd.a     = AW'(dterm_mag);
            cmd.b     = BW'(gain_d_ff);
            if (mrsp.done) begin
               corr_in  = corr_ff + dterm_t;
               state_in = ddrpb_pkg::ST_FIX;
            end
         end
         ddrpb_pkg::ST_FIX: begin
            left_in  = pid_l;
            right_in = pid_r;
            prev_in  = err;
            state_in = ddrpb_pkg::ST_OUT;
         end
         ddrpb_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {tele_ff, mode_ff, right_ff, left_ff};
               state_in     = ddrpb_pkg::ST_IDLE;
            end
         end
         default: state_in = ddrpb_pkg::ST_IDLE;
      endcase
   end

   assign issued_in = (issued_ff | cmd.start) & ~mrsp.done;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_data_ff};

endmodule

### hw/rtl/ddrpb_mdu.sv
module ddrpb_mdu (
   input  logic                  clock,
   input  logic                  reset,
   input  ddrpb_pkg::mdu_cmd_type cmd,
   output ddrpb_pkg::mdu_rsp_type rsp
);

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic                                is_div_ff, is_div_in;
   logic [ddrpb_pkg::CNT_W-1:0]         cnt_ff, cnt_in;
   logic [ddrpb_pkg::MUL_A_W-1:0]       mcand_ff, mcand_in;
   logic [ddrpb_pkg::MUL_A_W-1:0]       hi_ff, hi_in;
   logic [ddrpb_pkg::MUL_B_W-1:0]       lo_ff, lo_in;
   logic [ddrpb_pkg::OPA_W-1:0]         quo_ff, quo_in;
   logic [ddrpb_pkg::OPB_W-1:0]         rem_ff, rem_in;
   logic [ddrpb_pkg::OPB_W-1:0]         dvs_ff, dvs_in;
   logic [ddrpb_pkg::MUL_A_W:0]         msum;
   logic [ddrpb_pkg::OPB_W:0]           shifted;
   logic [ddrpb_pkg::OPB_W+1:0]         trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      is_div_ff <= is_div_in;
      cnt_ff    <= cnt_in;
      mcand_ff  <= mcand_in;
      hi_ff     <= hi_in;
      lo_ff     <= lo_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      dvs_ff    <= dvs_in;
   end

   // One multiplier bit or one quotient bit per cycle.
   assign msum    = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, mcand_ff} : '0);
   assign shifted = {rem_ff, quo_ff[ddrpb_pkg::OPA_W-1]};
   assign trial   = {1'b0, shifted} - {2'b00, dvs_ff};

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      is_div_in = is_div_ff;
      cnt_in    = cnt_ff;
      mcand_in  = mcand_ff;
      hi_in     = hi_ff;
      lo_in     = lo_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      dvs_in    = dvs_ff;
      if (busy_ff) begin
         if (is_div_ff) begin
            if (!trial[ddrpb_pkg::OPB_W+1]) begin
               rem_in = trial[ddrpb_pkg::OPB_W-1:0];
               quo_in = {quo_ff[ddrpb_pkg::OPA_W-2:0], 1'b1};
            end else begin
               rem_in = shifted[ddrpb_pkg::OPB_W-1:0];
               quo_in = {quo_ff[ddrpb_pkg::OPA_W-2:0], 1'b0};
            end
         end else begin
            hi_in = msum[ddrpb_pkg::MUL_A_W:1];
            lo_in = {msum[0], lo_ff[ddrpb_pkg::MUL_B_W-1:1]};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == ddrpb_pkg::CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (cmd.start) begin
         busy_in   = 1'b1;
         is_div_in = cmd.is_div;
         mcand_in  = cmd.a[ddrpb_pkg::MUL_A_W-1:0];
         hi_in     = '0;
         lo_in     = cmd.b[ddrpb_pkg::MUL_B_W-1:0];
         quo_in    = cmd.a;
         rem_in    = '0;
         dvs_in    = cmd.b;
         cnt_in    = cmd.is_div ? ddrpb_pkg::CNT_W'(ddrpb_pkg::OPA_W)
                                : ddrpb_pkg::CNT_W'(ddrpb_pkg::MUL_B_W);
      end
   end

   assign rsp.done = done_ff;
   assign rsp.res  = is_div_ff ? ddrpb_pkg::RES_W'(quo_ff) : {hi_ff, lo_ff};

endmodule

### hw/rtl/ddrpb_checker.sv
module ddrpb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata
);

   // A result beat that is not taken stays and holds its data.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result beat changed");

   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // A stop command drives both wheels to zero and reports zero speed.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[33:32] == ddrpb_pkg::MODE_STOP
      |-> rsp_tdata[31:0] == 32'd0 && rsp_tdata[42:34] == 9'd0)
      else $error("stop tick with nonzero output");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[33:32] <= ddrpb_pkg::MODE_BACK
                     && rsp_tdata[42:34] <= ddrpb_pkg::TELE_FULL
                     && rsp_tdata[47:43] == 5'd0)
      else $error("result fields out of range");

   // Two ticks are never accepted back to back.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("two ticks accepted back to back");

endmodule

bind diff_drive_ramp_pid_balancer ddrpb_checker u_ddrpb_checker (.*);

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam int  RAMP_STEPS  = 256;
   localparam longint CYCLE_LIMIT = 3000000;

   typedef struct packed {
      logic signed [15:0] wheel_r_speed;
      logic signed [15:0] wheel_l_speed;
      logic [15:0]        elapsed_ms;
      logic [7:0]         speed_cmd;
      logic signed [7:0]  turn;
      logic signed [7:0]  direction;
   } tick_type;

   typedef struct packed {
      logic [4:0]  fill;
      logic [8:0]  tele_speed;
      logic [1:0]  bridge_mode;
      logic [15:0] right_duty;
      logic [15:0] left_duty;
   } drive_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [22:0] csr_wdata;

   // Shadow of the control registers and the loop state.
   longint max_pwm, ramp_ms, period_ms, gain_p, gain_i, gain_d, int_limit;
   longint integ_acc, prev_err;

   drive_type drive_q[$];
   int     errors;
   int     ticks_sent;
   int     beats_checked;
   longint cycles;
   bit     send_busy;     // sender idles at random when set
   bit     recv_busy;     // receiver stalls at random when set

   diff_drive_ramp_pid_balancer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles, drive_q.size());
         $display("diff_drive_ramp_pid_balancer verification failed");
         $finish;
      end
   end

   function automatic longint floor_div(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b != 0) && (a < 0))
         q = q - 1;
      return q;
   endfunction

   function automatic longint clamp_duty(longint v);
      if (v < 0)
         return 0;
      if (v > max_pwm)
         return max_pwm;
      return v;
   endfunction

   function automatic longint sine_ratio(longint elapsed);
      longint k, x, u, t, r;
      if (elapsed >= ramp_ms)
         return 32768;
      k = elapsed * RAMP_STEPS / ramp_ms;
      x = k * 32768 / RAMP_STEPS;
      u = (x * x) >>> 15;
      t = 2611 - ((153 * u) >>> 15);
      t = 21167 - ((t * u) >>> 15);
      t = 51472 - ((t * u) >>> 15);
      r = (x * t) >>> 15;
      return (r > 32768) ? 32768 : r;
   endfunction

   // Computes the duties for one tick and advances the integral and previous error.
   function automatic drive_type predict_drive(tick_type tk);
      drive_type res;
      longint dir, trn, spd, target, left, right, per, e, d, corr;
      dir = tk.direction;
      trn = tk.turn;
      spd = tk.speed_cmd;
      per = (period_ms == 0) ? 1 : period_ms;
      if (dir > 1) dir = 1;
      if (dir < -1) dir = -1;
      if (trn > 1) trn = 1;
      if (trn < -1) trn = -1;
      if (spd > 100) spd = 100;
      target = 0;
      if (dir != 0)
         target = spd * max_pwm * sine_ratio(longint'(tk.elapsed_ms)) / 3276800;
      if (trn > 0) begin
         left = target * 4 / 5;
         right = target * 6 / 5;
      end else if (trn < 0) begin
         left = target * 6 / 5;
         right = target * 4 / 5;
      end else begin
         left = target;
         right = target;
      end
      left = clamp_duty(left);
      right = clamp_duty(right);
      if (dir != 0 && trn == 0 && target > 0) begin
         e = longint'(tk.wheel_l_speed) - longint'(tk.wheel_r_speed);
         integ_acc = integ_acc + (e * per * 256) / 1000;
         if (integ_acc > int_limit) integ_acc = int_limit;
         if (integ_acc < -int_limit) integ_acc = -int_limit;
         d = ((e - prev_err) * 1000) / per;
         corr = gain_p * e + floor_div(gain_i * integ_acc, 256) + gain_d * d;
         prev_err = e;
         left = clamp_duty(floor_div(left * 512 - corr, 512));
         right = clamp_duty(floor_div(right * 512 + corr, 512));
      end else begin
         integ_acc = 0;
      end
      res = '0;
      res.left_duty = left[15:0];
      res.right_duty = right[15:0];
      res.bridge_mode = (dir > 0) ? ddrpb_pkg::MODE_FWD
                      : ((dir < 0) ? ddrpb_pkg::MODE_BACK : ddrpb_pkg::MODE_STOP);
      res.tele_speed = (max_pwm != 0) ? 9'(target * 500 / max_pwm) : 9'd0;
      return res;
   endfunction

   task automatic send_tick(tick_type tk);
      int gap;
      gap = send_busy ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= tk;
      do @(posedge clock); while (!req_tready);
      drive_q.push_back(predict_drive(tk));
      ticks_sent++;
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      while (drive_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Writes all seven registers back to back; only called with the block idle.
   task automatic load_regs(longint mp, longint rm, longint pm, longint gp, longint gi,
                            longint gd, longint il);
      longint vals[7];
      vals = '{mp, rm, pm, gp, gi, gd, il};
      for (int i = 0; i < 7; i++) begin
         csr_we <= 1'b1;
         csr_index <= 3'(i);
         csr_wdata <= 23'(vals[i]);
         @(posedge clock);
      end
      csr_we <= 1'b0;
      max_pwm = mp & 16'hFFFF;
      ramp_ms = rm & 16'hFFFF;
      period_ms = pm & 10'h3FF;
      gain_p = gp & 16'hFFFF;
      gain_i = gi & 16'hFFFF;
      gain_d = gd & 16'hFFFF;
      int_limit = il & 23'h7FFFFF;
   endtask

   function automatic tick_type make_tick(int dir, int trn, int spd, int el, int l, int r);
      tick_type tk;
      tk.direction = 8'(dir);
      tk.turn = 8'(trn);
      tk.speed_cmd = 8'(spd);
      tk.elapsed_ms = 16'(el);
      tk.wheel_l_speed = 16'(l);
      tk.wheel_r_speed = 16'(r);
      return tk;
   endfunction

   // Mostly plausible driving ticks, with full-range noise mixed in.
   function automatic tick_type random_tick();
      tick_type tk;
      int base;
      tk = tick_type'(72'({$urandom, $urandom, $urandom}));
      if ($urandom_range(0, 9) < 8) begin
         tk.direction = ($urandom_range(0, 7) == 0) ? 8'sd0 :
                        ($urandom_range(0, 1) ? 8'sd1 : -8'sd1);
         tk.turn = ($urandom_range(0, 3) == 0) ? 8'(int'($urandom_range(0, 2)) - 1) : 8'sd0;
         tk.speed_cmd = 8'($urandom_range(0, 110));
         tk.elapsed_ms = 16'($urandom_range(0, (ramp_ms > 0) ? int'(ramp_ms) + 50 : 100));
         base = $urandom_range(0, 600) - 300;
         tk.wheel_l_speed = 16'(base + int'($urandom_range(0, 80)) - 40);
         tk.wheel_r_speed = 16'(base + int'($urandom_range(0, 80)) - 40);
      end
      return tk;
   endfunction

   task automatic random_phase(int n);
      for (int i = 0; i < n; i++) begin
         if (i % 60 == 0) begin
            send_busy = $urandom_range(0, 3) != 0;
            recv_busy = $urandom_range(0, 3) != 0;
         end
         send_tick(random_tick());
      end
      drain();
   endtask

   task automatic test_directed;
      send_tick(make_tick(1, 0, 100, 65535, 0, 0));
      send_tick(make_tick(127, 0, 255, 600, 120, 100));
      send_tick(make_tick(127, 0, 255, 600, 140, 100));
      send_tick(make_tick(-128, 0, 50, 250, 100, 140));
      send_tick(make_tick(-1, -128, 100, 0, 0, 0));
      send_tick(make_tick(1, 127, 100, 499, 0, 0));
      send_tick(make_tick(1, -1, 100, 600, -32768, 32767));
      send_tick(make_tick(0, 0, 100, 600, 32767, -32768));
      send_tick(make_tick(1, 0, 0, 600, 10, 0));
      send_tick(make_tick(1, 0, 100, 600, 32767, -32768));
      send_tick(make_tick(1, 0, 100, 600, -32768, 32767));
      send_tick(make_tick(-1, 1, 255, 65535, -1, -1));
      drain();
      // Zero period, zero ramp and full-scale gains.
      load_regs(65535, 0, 0, 65535, 65535, 65535, 8388607);
      send_tick(make_tick(1, 0, 100, 0, 500, 0));
      send_tick(make_tick(1, 0, 100, 0, 32767, -32768));
      send_tick(make_tick(-1, 0, 73, 1, -32768, 32767));
      send_tick(make_tick(1, 1, 100, 0, 0, 0));
      drain();
      // Zero full-scale duty.
      load_regs(0, 1, 1000, 0, 0, 0, 0);
      send_tick(make_tick(1, 0, 100, 0, 50, 0));
      send_tick(make_tick(-1, -1, 255, 65535, 0, 5));
      drain();
   endtask

   task automatic test_random;
      load_regs(255, 500, 10, 256, 0, 0, 25600);
      random_phase(240);
      load_regs(1023, 200, 20, 512, 64, 16, 50000);
      random_phase(240);
      load_regs(65535, 65535, 1000, 65535, 65535, 65535, 8388607);
      random_phase(240);
      load_regs(1, 1, 1, 0, 0, 0, 0);
      random_phase(240);
      load_regs($urandom_range(1, 65535), $urandom_range(1, 3000), $urandom_range(1, 1000),
                $urandom_range(0, 65535), $urandom_range(0, 65535),
                $urandom_range(0, 65535), $urandom_range(0, 8388607));
      random_phase(240);
      load_regs($urandom_range(100, 4000), $urandom_range(1, 1000), $urandom_range(1, 50),
                $urandom_range(0, 2048), $urandom_range(0, 1024),
                $urandom_range(0, 256), $urandom_range(0, 100000));
      random_phase(230);
   endtask

   // Response side: random stalls, then each beat is checked against the oldest prediction.
   initial begin
      drive_type got, want;
      int stall;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         stall = recv_busy ? $urandom_range(0, 5) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         got = drive_type'(rsp_tdata);
         beats_checked++;
         if (drive_q.size() == 0) begin
            $display("%0t: result beat with nothing expected, got %h", $time, rsp_tdata);
            errors++;
         end else begin
            want = drive_q.pop_front();
            if (got.left_duty !== want.left_duty) begin
               $display("%0t: left_duty expected %0d actual %0d", $time,
                        want.left_duty, got.left_duty);
               errors++;
            end
            if (got.right_duty !== want.right_duty) begin
               $display("%0t: right_duty expected %0d actual %0d", $time,
                        want.right_duty, got.right_duty);
               errors++;
            end
            if (got.bridge_mode !== want.bridge_mode) begin
               $display("%0t: bridge_mode expected %0d actual %0d", $time,
                        want.bridge_mode, got.bridge_mode);
               errors++;
            end
            if (got.tele_speed !== want.tele_speed) begin
               $display("%0t: reported speed expected %0d actual %0d", $time,
                        want.tele_speed, got.tele_speed);
               errors++;
            end
         end
      end
   end

   initial begin
      errors = 0;
      ticks_sent = 0;
      beats_checked = 0;
      cycles = 0;
      send_busy = 1'b1;
      recv_busy = 1'b1;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      max_pwm = 255;
      ramp_ms = 500;
      period_ms = 10;
      gain_p = 256;
      gain_i = 0;
      gain_d = 0;
      int_limit = 25600;
      integ_acc = 0;
      prev_err = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random();
      $display("sent %0d ticks over nine register settings, checked %0d result beats",
               ticks_sent, beats_checked);
      $display("covered stop, turns, straight PID, zero period, ramp and full-scale cases");
      if (errors == 0 && drive_q.size() == 0) begin
         $display("diff_drive_ramp_pid_balancer verification clean");
      end else begin
         $display("%0d mismatches, %0d results never arrived", errors, drive_q.size());
         $display("diff_drive_ramp_pid_balancer verification failed");
      end
      $finish;
   end

endmodule
